// File: hw/rtl/tournament_branch_predictor_macros.svh
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication on clk, off while reset is low
`define TBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off while reset is low
`define TBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tbp_pkg.sv
`default_nettype none

package tbp_pkg;

    localparam int GHIST_BITS = 9;
    localparam int LHIST_BITS = 10;
    localparam int PC_IDX_BITS = 10;

    // clear sweep covers the deepest table
    localparam int CLR_BITS_GL = (GHIST_BITS > LHIST_BITS) ? GHIST_BITS : LHIST_BITS;
    localparam int CLR_BITS = (CLR_BITS_GL > PC_IDX_BITS) ? CLR_BITS_GL : PC_IDX_BITS;

    localparam logic [1:0] MODE_STATIC = 2'd0;
    localparam logic [1:0] MODE_TOURN  = 2'd1;
    localparam logic [1:0] MODE_NONE   = 2'd2;

    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_TRAIN   = 1'b1;

    localparam logic [1:0] CTR_MIN          = 2'd0;
    localparam logic [1:0] CTR_MAX          = 2'd3;
    localparam logic [1:0] CHOOSER_INIT     = 2'd2;

    typedef logic [1:0] ctr_t;

    // stage 1: accepted beat plus global history seen at accept
    typedef struct packed {
        logic                   vld;
        logic                   is_pred;
        logic                   train_en;
        logic [1:0]             mode;
        logic                   taken;
        logic [PC_IDX_BITS-1:0] pc_idx;
        logic [GHIST_BITS-1:0]  ghist;
    } s1_t;

    // stage 2: local history resolved
    typedef struct packed {
        logic                   vld;
        logic                   is_pred;
        logic                   train_en;
        logic [1:0]             mode;
        logic                   taken;
        logic [PC_IDX_BITS-1:0] pc_idx;
        logic [GHIST_BITS-1:0]  ghist;
        logic [LHIST_BITS-1:0]  lhist;
        logic [LHIST_BITS-1:0]  lhist_new;
    } s2_t;

    // counter writes done at the last advance
    typedef struct packed {
        logic                   vld;
        logic [GHIST_BITS-1:0]  ghist;
        logic [LHIST_BITS-1:0]  lhist;
        ctr_t                   ch;
        ctr_t                   gc;
        ctr_t                   lc;
    } wrec_t;

    function automatic ctr_t sat_bump(input ctr_t ctr, input logic up);
        ctr_t res;
        res = ctr;
        if (up)
        begin
            if (ctr != CTR_MAX)
            begin
                res = ctr + 2'd1;
            end
        end
        else
        begin
            if (ctr != CTR_MIN)
            begin
                res = ctr - 2'd1;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tournament_branch_predictor.sv
`default_nettype none

// channel  | dir | handshake           | beat
// ---------+-----+---------------------+----------------------------------
// req      | in  | req_valid/req_stall | req_type, branch_pc, branch_taken
// rsp      | out | rsp_valid/rsp_stall | predict_taken (predict beats only)
// cfg      | in  | cfg_wr_en           | cfg_wr_data -> predictor_mode
//
// one req beat per clock while req_stall is low; a predict result passes stage 1, stage 2 and
// the output register before it shows on rsp, trains give no rsp beat
// after reset a sweep over all 2**CLR_BITS indices (1024 here) clears the tables, req_stall high
// a result held on rsp under rsp_stall freezes all three stages and stalls req
// the pipeline depth comes from the dependent reads of local history and
// then local counter, each a stage with a registered read port
module tournament_branch_predictor
    import tbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic        req_type,
    input  wire logic [31:0] branch_pc,
    input  wire logic        branch_taken,

    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic             predict_taken,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data
);

    localparam int GDEPTH = 2 ** GHIST_BITS;
    localparam int LDEPTH = 2 ** LHIST_BITS;
    localparam int PDEPTH = 2 ** PC_IDX_BITS;

    // tables
    ctr_t                  chooser_mem [GDEPTH];
    ctr_t                  gctr_mem    [GDEPTH];
    ctr_t                  lctr_mem    [LDEPTH];
    logic [LHIST_BITS-1:0] lhist_mem   [PDEPTH];

    // control
    logic [1:0]            mode_reg;
    logic [GHIST_BITS-1:0] ghr_reg;
    logic [GHIST_BITS-1:0] ghr_next;
    logic                  clearing_reg;
    logic [CLR_BITS-1:0]   clr_idx_reg;

    s1_t                   s1_reg, s1_next;
    s2_t                   s2_reg, s2_next;
    wrec_t                 w_reg, w_next;

    logic                  out_vld_reg, out_vld_next;
    logic                  out_pred_reg;

    // registered read data
    logic [LHIST_BITS-1:0] lh_rdata_reg;
    ctr_t                  ch_rdata_reg;
    ctr_t                  gc_rdata_reg;
    ctr_t                  lc_rdata_reg;

    logic                  adv;
    logic                  accept;

    // stage 1 signals
    logic [LHIST_BITS-1:0] lh_cur;
    logic [LHIST_BITS-1:0] lh_new;
    logic                  lh_we;

    // stage 2 signals
    ctr_t                  ch_cur, gc_cur, lc_cur;
    ctr_t                  ch_upd, gc_upd, lc_upd;
    logic                  gp, lp;
    logic                  pred;
    logic                  ctr_we;

    // memory write ports, shared with the clearing sweep
    logic                  ch_we, lc_we, lhm_we;
    logic [GHIST_BITS-1:0] g_waddr;
    logic [LHIST_BITS-1:0] l_waddr;
    logic [PC_IDX_BITS-1:0] p_waddr;
    ctr_t                  ch_wdata, gc_wdata, lc_wdata;
    logic [LHIST_BITS-1:0] lhm_wdata;

    // whole pipe moves unless a result is stuck on rsp
    assign adv       = !(out_vld_reg && rsp_stall);
    assign req_stall = clearing_reg || !adv;
    assign accept    = req_valid && !req_stall;

    assign rsp_valid     = out_vld_reg;
    assign predict_taken = out_pred_reg;

    // accept: capture beat and global history, history shifts right away on a tournament-mode train
    always_comb
    begin
        s1_next.vld      = accept;
        s1_next.is_pred  = (req_type == REQ_PREDICT);
        s1_next.train_en = (req_type == REQ_TRAIN) && (mode_reg == MODE_TOURN);
        s1_next.mode     = mode_reg;
        s1_next.taken    = branch_taken;
        s1_next.pc_idx   = branch_pc[PC_IDX_BITS-1:0];
        s1_next.ghist    = ghr_reg;

        ghr_next = ghr_reg;
        if (accept && s1_next.train_en)
        begin
            ghr_next = GHIST_BITS'({ghr_reg, branch_taken});
        end
    end

    // stage 1: local history, bypassing the write of the item just ahead
    always_comb
    begin
        lh_cur = lh_rdata_reg;
        if (s2_reg.vld && s2_reg.train_en && (s2_reg.pc_idx == s1_reg.pc_idx))
        begin
            lh_cur = s2_reg.lhist_new;
        end
        lh_new = LHIST_BITS'({lh_cur, s1_reg.taken});
        lh_we  = adv && s1_reg.vld && s1_reg.train_en;

        s2_next.vld       = s1_reg.vld;
        s2_next.is_pred   = s1_reg.is_pred;
        s2_next.train_en  = s1_reg.train_en;
        s2_next.mode      = s1_reg.mode;
        s2_next.taken     = s1_reg.taken;
        s2_next.pc_idx    = s1_reg.pc_idx;
        s2_next.ghist     = s1_reg.ghist;
        s2_next.lhist     = lh_cur;
        s2_next.lhist_new = lh_new;
    end

    // stage 2: counters, bypassing the writes of the previous advance
    always_comb
    begin
        ch_cur = ch_rdata_reg;
        gc_cur = gc_rdata_reg;
        lc_cur = lc_rdata_reg;
        if (w_reg.vld && (w_reg.ghist == s2_reg.ghist))
        begin
            ch_cur = w_reg.ch;
            gc_cur = w_reg.gc;
        end
        if (w_reg.vld && (w_reg.lhist == s2_reg.lhist))
        begin
            lc_cur = w_reg.lc;
        end

        gp = gc_cur[1];
        lp = lc_cur[1];

        unique case (s2_reg.mode)
            MODE_STATIC: pred = 1'b1;
            MODE_TOURN:  pred = ch_cur[1] ? gp : lp;
            default:     pred = 1'b0;
        endcase

        // chooser leans toward whichever side alone was right
        ch_upd = ch_cur;
        if ((gp == s2_reg.taken) && (lp != s2_reg.taken))
        begin
            ch_upd = sat_bump(ch_cur, 1'b1);
        end
        else if ((lp == s2_reg.taken) && (gp != s2_reg.taken))
        begin
            ch_upd = sat_bump(ch_cur, 1'b0);
        end
        gc_upd = sat_bump(gc_cur, s2_reg.taken);
        lc_upd = sat_bump(lc_cur, s2_reg.taken);

        ctr_we = adv && s2_reg.vld && s2_reg.train_en;

        w_next.vld   = ctr_we;
        w_next.ghist = s2_reg.ghist;
        w_next.lhist = s2_reg.lhist;
        w_next.ch    = ch_upd;
        w_next.gc    = gc_upd;
        w_next.lc    = lc_upd;

        out_vld_next = s2_reg.vld && s2_reg.is_pred;
    end

    // write port muxing, sweep and pipe never overlap
    always_comb
    begin
        if (clearing_reg)
        begin
            ch_we     = 1'b1;
            lc_we     = 1'b1;
            lhm_we    = 1'b1;
            g_waddr   = clr_idx_reg[GHIST_BITS-1:0];
            l_waddr   = clr_idx_reg[LHIST_BITS-1:0];
            p_waddr   = clr_idx_reg[PC_IDX_BITS-1:0];
            ch_wdata  = CHOOSER_INIT;
            gc_wdata  = CTR_MIN;
            lc_wdata  = CTR_MIN;
            lhm_wdata = '0;
        end
        else
        begin
            ch_we     = ctr_we;
            lc_we     = ctr_we;
            lhm_we    = lh_we;
            g_waddr   = s2_reg.ghist;
            l_waddr   = s2_reg.lhist;
            p_waddr   = s1_reg.pc_idx;
            ch_wdata  = ch_upd;
            gc_wdata  = gc_upd;
            lc_wdata  = lc_upd;
            lhm_wdata = lh_new;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_TOURN;
            ghr_reg      <= '0;
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            s1_reg       <= '0;
            s2_reg       <= '0;
            w_reg        <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + CLR_BITS'(1);
                if (clr_idx_reg == '1)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            ghr_reg <= ghr_next;
            if (adv)
            begin
                s1_reg      <= s1_next;
                s2_reg      <= s2_next;
                w_reg       <= w_next;
                out_vld_reg <= out_vld_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (adv && out_vld_next)
        begin
            out_pred_reg <= pred;
        end
    end

    // local history table: read at accept, written from stage 1
    always_ff @(posedge clk)
    begin
        if (lhm_we)
        begin
            lhist_mem[p_waddr] <= lhm_wdata;
        end
        if (adv)
        begin
            lh_rdata_reg <= lhist_mem[branch_pc[PC_IDX_BITS-1:0]];
        end
    end

    // chooser and global counters: read from stage 1, written from stage 2
    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            chooser_mem[g_waddr] <= ch_wdata;
            gctr_mem[g_waddr]    <= gc_wdata;
        end
        if (adv)
        begin
            ch_rdata_reg <= chooser_mem[s1_reg.ghist];
            gc_rdata_reg <= gctr_mem[s1_reg.ghist];
        end
    end

    // local counters: read at the resolved local history
    always_ff @(posedge clk)
    begin
        if (lc_we)
        begin
            lctr_mem[l_waddr] <= lc_wdata;
        end
        if (adv)
        begin
            lc_rdata_reg <= lctr_mem[lh_cur];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tbp_checker.sv
`default_nettype none

`include "tournament_branch_predictor_macros.svh"

module tbp_checker
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_stall,
    input  wire logic rsp_valid,
    input  wire logic rsp_stall,
    input  wire logic predict_taken
);

    logic req_beat;
    assign req_beat = req_valid && !req_stall;

    `TBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(predict_taken), "rsp beat changed under stall")
    `TBP_ASSERT_SAME(a_rsp_drop, $fell(rsp_valid), $past(!rsp_stall), "rsp beat dropped before taken")
    `TBP_ASSERT_SAME(a_full_stall, rsp_valid && rsp_stall, !req_beat, "req taken while pipe frozen")
    `TBP_ASSERT_SAME(a_clear_stall, !$past(rst_n), req_stall, "req open during table clear")

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .predict_taken (predict_taken)
);

`default_nettype wire
